@@ src/aabb_pkg.sv @@
// aabb_pkg: shared types and constants for the box-pair overlap event block
// no dependencies; imported by aabb_pair_overlap_events and its testbench
package aabb_pkg;

  localparam int ID_BITS     = 6;
  localparam int COORD_BITS  = 16;
  localparam int ADDR_BITS   = 2 * ID_BITS;
  localparam int TABLE_DEPTH = 1 << ADDR_BITS;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEGIN = 2'd1,
    EV_STAY  = 2'd2,
    EV_END   = 2'd3
  } event_e;

  typedef struct packed {
    logic [ID_BITS-1:0]           first_id;
    logic [ID_BITS-1:0]           second_id;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0]        first_w;
    logic [COORD_BITS-1:0]        first_h;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0]        second_w;
    logic [COORD_BITS-1:0]        second_h;
    logic                         first_dead;
    logic                         second_dead;
  } pair_in_t;

  typedef struct packed {
    event_e event_res;
    logic   touching;
  } pair_out_t;

endpackage

@@ src/aabb_ram.sv @@
// aabb_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module aabb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/aabb_pair_overlap_events.sv @@
// aabb_pair_overlap_events: enter/stay/exit events for ordered pairs of axis-aligned boxes
// depends on aabb_pkg and aabb_ram
//
// Usage:
// An item is one ordered collider pair (ids, centers, full sizes, dead flags) on
// item_i. It is taken at a rising edge where start is high and busy is low.
// Every item gives exactly one result on res_o, shown for one cycle with
// res_valid_o high after the item has passed the stage 1 and output registers.
// The receiver cannot stall; each result must be taken in the cycle it is shown.
// Throughput is one item per clock while busy is low. The overlap history lives
// in a 4096 x 1 table ram with a registered read port: the entry is read in the
// accept cycle, and written back in the next. A pair repeated in back-to-back
// cycles gets the last written bit from a bypass register, so any mix of repeats
// runs at full rate. After reset the table is swept to zero, one entry per cycle:
// busy stays high until every entry is cleared, and no item is taken during
// that time.
module aabb_pair_overlap_events
  import aabb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pair_in_t  item_i,
  output logic      res_valid_o,
  output pair_out_t res_o
);

  localparam int DW = COORD_BITS + 1;

  // control
  logic                 clearing_q;
  logic [ADDR_BITS-1:0] clr_cnt_q;
  logic                 accept;

  // stage 1 registers
  logic                 s1_valid_q;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic                 s1_dead_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q;
  logic [DW-1:0]        s1_sw_q, s1_sh_q;

  // stage 0 combinational
  logic [ADDR_BITS-1:0] s0_addr;
  logic signed [DW-1:0] dx_d, dy_d;
  logic [DW-1:0]        sw_d, sh_d;

  // stage 1 combinational
  logic [DW-1:0] adx, ady;
  logic          touch_d;
  logic          prev_bit;
  logic          ram_rdata;
  event_e        event_d;

  // write port and bypass
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic                 ram_wdata;
  logic                 fwd_valid_q;
  logic [ADDR_BITS-1:0] fwd_addr_q;
  logic                 fwd_data_q;

  // output
  logic      res_valid_q;
  pair_out_t res_q;

  assign busy   = clearing_q;
  assign accept = start && !busy;

  assign s0_addr = {item_i.first_id, item_i.second_id};
  assign dx_d = DW'(item_i.first_x) - DW'(item_i.second_x);
  assign dy_d = DW'(item_i.first_y) - DW'(item_i.second_y);
  assign sw_d = {1'b0, item_i.first_w} + {1'b0, item_i.second_w};
  assign sh_d = {1'b0, item_i.first_h} + {1'b0, item_i.second_h};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == {ADDR_BITS{1'b1}}) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= s0_addr;
      s1_dead_q <= item_i.first_dead | item_i.second_dead;
      s1_dx_q   <= dx_d;
      s1_dy_q   <= dy_d;
      s1_sw_q   <= sw_d;
      s1_sh_q   <= sh_d;
    end
  end

  aabb_ram #(
    .WIDTH(1),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(s0_addr),
    .rdata_o(ram_rdata)
  );

  // absolute center distance, then size sum against twice the distance
  assign adx = s1_dx_q[DW-1] ? DW'(-s1_dx_q) : DW'(s1_dx_q);
  assign ady = s1_dy_q[DW-1] ? DW'(-s1_dy_q) : DW'(s1_dy_q);
  assign touch_d = ({1'b0, s1_sw_q} >= {adx, 1'b0}) && ({1'b0, s1_sh_q} >= {ady, 1'b0});

  // the write issued last cycle is not yet visible in the read data
  assign prev_bit = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;

  always_comb begin
    unique case ({prev_bit, touch_d})
      2'b01:   event_d = s1_dead_q ? EV_NONE : EV_BEGIN;
      2'b11:   event_d = s1_dead_q ? EV_END : EV_STAY;
      2'b10:   event_d = EV_END;
      default: event_d = EV_NONE;
    endcase
  end

  assign ram_we    = clearing_q || s1_valid_q;
  assign ram_waddr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clearing_q ? 1'b0 : touch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= ram_waddr;
    fwd_data_q <= ram_wdata;
    if (s1_valid_q) begin
      res_q.event_res <= event_d;
      res_q.touching  <= touch_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // once the sweep is done the block never blocks again
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy |=> !busy)
    else $error("busy rose after the table sweep");

  // every accepted item yields its result after the stage 1 and output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> ##1 res_valid_o)
    else $error("result missing two cycles after accept");

  // nothing comes out while the table is still being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> !res_valid_o)
    else $error("result shown during table sweep");

  // begin and stay only happen while touching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_res == EV_BEGIN || res_o.event_res == EV_STAY))
      |-> res_o.touching)
    else $error("begin or stay without overlap");

endmodule

@@ verif/aabb_pair_overlap_events_tb.sv @@
// aabb_pair_overlap_events_tb: self-checking bench for the box-pair overlap event block
// depends on aabb_pkg and the aabb_pair_overlap_events rtl; a scoreboard class predicts
// each event from its own copy of the pair history table
module aabb_pair_overlap_events_tb
  import aabb_pkg::*;
();

  localparam int RANDOM_PAIRS   = 1250;
  localparam int TIMEOUT_CYCLES = 100000;

  class overlap_scoreboard;
    bit        touch_history [TABLE_DEPTH];
    pair_out_t expected_q [$];
    int        errors;

    function new();
      errors = 0;
      foreach (touch_history[i]) touch_history[i] = 1'b0;
    endfunction

    // exact half-size test on one axis, no division
    static function bit axis_meets(logic signed [COORD_BITS-1:0] pa, logic [COORD_BITS-1:0] sa,
                                   logic signed [COORD_BITS-1:0] pb, logic [COORD_BITS-1:0] sb);
      longint span;
      longint gap;
      span = longint'(sa) + longint'(sb);
      gap  = longint'(pa) - longint'(pb);
      if (gap < 0) gap = -gap;
      return span >= 2 * gap;
    endfunction

    function void note_pair(pair_in_t p);
      logic [ADDR_BITS-1:0] slot;
      bit                   hit;
      bit                   was;
      bit                   dead;
      pair_out_t            exp;
      slot = {p.first_id, p.second_id};
      hit  = axis_meets(p.first_x, p.first_w, p.second_x, p.second_w) &&
             axis_meets(p.first_y, p.first_h, p.second_y, p.second_h);
      dead = p.first_dead | p.second_dead;
      was  = touch_history[slot];
      exp.event_res = EV_NONE;
      if (hit) begin
        if (!was) exp.event_res = dead ? EV_NONE : EV_BEGIN;
        else      exp.event_res = dead ? EV_END : EV_STAY;
      end else if (was) begin
        exp.event_res = EV_END;
      end
      exp.touching = hit;
      touch_history[slot] = hit;
      expected_q.push_back(exp);
    endfunction

    function void check_result(pair_out_t got);
      pair_out_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got event %0d touching %0b",
                 $time, got.event_res, got.touching);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.event_res !== exp.event_res) begin
        $display("%0t: event mismatch, expected %0d got %0d", $time, exp.event_res, got.event_res);
        errors++;
      end
      if (got.touching !== exp.touching) begin
        $display("%0t: touching mismatch, expected %0b got %0b", $time, exp.touching,
                 got.touching);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  pair_in_t  pair_item;
  logic      res_valid_o;
  pair_out_t res_o;

  overlap_scoreboard board = new();
  pair_in_t          pair_stream [$];

  aabb_pair_overlap_events dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (pair_item),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_pair(pair_item);
      if (res_valid_o) board.check_result(res_o);
    end
  end

  function automatic pair_in_t pack_pair(
      int fid, int sid, int fx, int fy, int fw, int fh,
      int sx, int sy, int sw, int sh, bit fd, bit sd);
    pair_in_t p;
    p.first_id    = fid[ID_BITS-1:0];
    p.second_id   = sid[ID_BITS-1:0];
    p.first_x     = fx[COORD_BITS-1:0];
    p.first_y     = fy[COORD_BITS-1:0];
    p.first_w     = fw[COORD_BITS-1:0];
    p.first_h     = fh[COORD_BITS-1:0];
    p.second_x    = sx[COORD_BITS-1:0];
    p.second_y    = sy[COORD_BITS-1:0];
    p.second_w    = sw[COORD_BITS-1:0];
    p.second_h    = sh[COORD_BITS-1:0];
    p.first_dead  = fd;
    p.second_dead = sd;
    return p;
  endfunction

  // small pool so ordered pairs come back often and the history matters
  function automatic int pick_id();
    int pool [6] = '{0, 1, 2, 3, 62, 63};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 5)];
    return $urandom_range(0, 63);
  endfunction

  // one axis: mostly near the touch boundary, some fully random bits
  function automatic void make_axis(output int pa, output int sa, output int pb, output int sb);
    int mode;
    int base;
    int d;
    int target;
    int lo;
    int hi;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      pa = $urandom_range(0, 65535);
      pb = $urandom_range(0, 65535);
      sa = $urandom_range(0, 65535);
      sb = $urandom_range(0, 65535);
    end else begin
      d = (mode < 8) ? $urandom_range(0, 300) : $urandom_range(0, 32767);
      if ($urandom_range(0, 1)) d = -d;
      base = int'($urandom_range(0, 65535)) - 32768;
      if (base + d > 32767) base = 32767 - d;
      if (base + d < -32768) base = -32768 - d;
      target = 2 * (d < 0 ? -d : d) + int'($urandom_range(0, 4)) - 2;
      if (target < 0) target = 0;
      lo = (target > 65535) ? target - 65535 : 0;
      hi = (target < 65535) ? target : 65535;
      pa = base;
      pb = base + d;
      sa = $urandom_range(hi, lo);
      sb = target - sa;
    end
  endfunction

  function automatic pair_in_t random_pair();
    int fx, fy, fw, fh, sx, sy, sw, sh;
    make_axis(fx, fw, sx, sw);
    make_axis(fy, fh, sy, sh);
    return pack_pair(pick_id(), pick_id(), fx, fy, fw, fh, sx, sy, sw, sh,
                     $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12);
  endfunction

  task automatic send_pair(input pair_in_t p);
    start     <= 1'b1;
    pair_item <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic build_directed();
    // corner to corner at full size lands exactly on the boundary
    pair_stream.push_back(pack_pair(0, 0, -32768, -32768, 65535, 65535,
                                    32767, 32767, 65535, 65535, 0, 0));
    pair_stream.push_back(pack_pair(0, 0, -32768, -32768, 65535, 65535,
                                    32767, 32767, 65534, 65535, 0, 0));
    pair_stream.push_back(pack_pair(0, 0, -32768, -32768, 65535, 65535,
                                    32767, 32767, 65534, 65535, 0, 0));
    // zero-size boxes on the same center still touch
    pair_stream.push_back(pack_pair(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_stream.push_back(pack_pair(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // dead while touching repeats end
    pair_stream.push_back(pack_pair(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    pair_stream.push_back(pack_pair(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    pair_stream.push_back(pack_pair(63, 63, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // dead on first touch gives none but arms the history
    pair_stream.push_back(pack_pair(5, 9, 10, 10, 40, 40, 20, 20, 40, 40, 1, 1));
    pair_stream.push_back(pack_pair(5, 9, 10, 10, 40, 40, 20, 20, 40, 40, 0, 0));
    // reversed order is its own entry
    pair_stream.push_back(pack_pair(9, 5, 10, 10, 40, 40, 20, 20, 40, 40, 0, 0));
    pair_stream.push_back(pack_pair(5, 9, 10, 10, 4, 4, 200, 20, 4, 4, 0, 0));
    pair_stream.push_back(pack_pair(9, 5, 0, 0, 40, 4, 10, 500, 40, 4, 0, 0));
    pair_stream.push_back(pack_pair(9, 5, 0, 0, 4, 40, 500, 10, 4, 40, 0, 0));
    // exact boundary on y, then one below
    pair_stream.push_back(pack_pair(42, 21, 7, 100, 1, 200, 7, -100, 1, 200, 0, 0));
    pair_stream.push_back(pack_pair(42, 21, 7, 100, 1, 199, 7, -100, 1, 200, 0, 0));
    pair_stream.push_back(pack_pair(21, 42, -5000, 0, 8, 8, 5000, 0, 8, 8, 1, 1));
    pair_stream.push_back(pack_pair(42, 21, 7, 100, 1, 200, 7, -100, 1, 200, 1, 1));
    pair_stream.push_back(pack_pair(42, 21, 7, 100, 1, 200, 7, -100, 1, 200, 0, 0));
    pair_stream.push_back(pack_pair(0, 63, 32767, -32768, 0, 0, 32767, -32768, 0, 0, 0, 0));
    pair_stream.push_back(pack_pair(63, 0, 21845, -21846, 43690, 21845,
                                    -21846, 21845, 21845, 43690, 0, 0));
    pair_stream.push_back(pack_pair(63, 0, 0, 0, 65535, 65535, 0, 0, 65535, 65535, 1, 0));
  endtask

  initial begin
    int burst;
    int gap;
    rst_ni    = 1'b0;
    start     = 1'b0;
    pair_item = '0;
    build_directed();
    repeat (RANDOM_PAIRS) pair_stream.push_back(random_pair());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pair_stream.size() != 0) begin
      // occasional long stretch with no gaps at all
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      while (burst > 0 && pair_stream.size() != 0) begin
        send_pair(pair_stream.pop_front());
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("aabb_pair_overlap_events verification clean");
    end else begin
      $display("aabb_pair_overlap_events verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("aabb_pair_overlap_events verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/aabb_pkg.sv
src/aabb_ram.sv
src/aabb_pair_overlap_events.sv
verif/aabb_pair_overlap_events_tb.sv
